@@ sv/assert_macros.svh @@
// Assertion macros shared by the CoAP message parser RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define CMP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CMP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define CMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ sv/cmp_pkg.sv @@
// Types and constants of the CoAP message parser.
// No dependencies; used by cmp_result_if and all parser modules.
package cmp_pkg;

    // Width of the payload offset and count fields of a result word.
    localparam int unsigned PAY_W  = 11;
    // Width of the option value skip counter (two-byte extension plus 269).
    localparam int unsigned SKIP_W = 17;

    // Parse phases.
    localparam logic [3:0] PH_HEADER  = 4'd0;
    localparam logic [3:0] PH_TOKEN   = 4'd1;
    localparam logic [3:0] PH_OPTION  = 4'd2;
    localparam logic [3:0] PH_DEXT1   = 4'd3;
    localparam logic [3:0] PH_DEXT2A  = 4'd4;
    localparam logic [3:0] PH_DEXT2B  = 4'd5;
    localparam logic [3:0] PH_LEXT1   = 4'd6;
    localparam logic [3:0] PH_LEXT2A  = 4'd7;
    localparam logic [3:0] PH_LEXT2B  = 4'd8;
    localparam logic [3:0] PH_SKIP    = 4'd9;
    localparam logic [3:0] PH_PAYLOAD = 4'd10;
    localparam logic [3:0] PH_ERROR   = 4'd11;

    // Result status codes.
    localparam logic [2:0] ST_OK_NONE   = 3'd0;
    localparam logic [2:0] ST_OK_PAY    = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_TOKEN     = 3'd3;
    localparam logic [2:0] ST_EXT_CUT   = 3'd4;
    localparam logic [2:0] ST_NIBBLE15  = 3'd5;
    localparam logic [2:0] ST_OPT_OVER  = 3'd6;
    localparam logic [2:0] ST_TOO_LONG  = 3'd7;

    // Special byte and nibble values of the option encoding.
    localparam logic [7:0] PAYLOAD_MARKER = 8'hFF;
    localparam logic [3:0] NIB_EXT1       = 4'd13;
    localparam logic [3:0] NIB_EXT2       = 4'd14;
    localparam logic [3:0] NIB_RESERVED   = 4'd15;
    localparam logic [SKIP_W-1:0] EXT1_BIAS = SKIP_W'(13);
    localparam logic [SKIP_W-1:0] EXT2_BIAS = SKIP_W'(269);

    // One message byte held in the input register.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cmp_byte_t;

    // One result word.
    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       msg_code;
        logic [3:0]       token_len;
        logic [PAY_W-1:0] payload_start;
        logic [PAY_W-1:0] payload_bytes;
    } cmp_result_t;

endpackage

@@ sv/cmp_msg_if.sv @@
// Byte channel into the CoAP message parser: valid/ready plus one message byte.
// Depends on nothing else.
interface cmp_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

@@ sv/cmp_result_if.sv @@
// Result channel out of the CoAP message parser: valid/ready plus one result word.
// Depends on cmp_pkg for the payload field width.
interface cmp_result_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                status;
    logic [7:0]                msg_code;
    logic [3:0]                token_len;
    logic [cmp_pkg::PAY_W-1:0] payload_start;
    logic [cmp_pkg::PAY_W-1:0] payload_bytes;

    modport source (output valid, output status, output msg_code, output token_len,
                    output payload_start, output payload_bytes, input ready);
    modport sink   (input valid, input status, input msg_code, input token_len,
                    input payload_start, input payload_bytes, output ready);
endinterface

@@ sv/cmp_byte_stage.sv @@
// Input register of the CoAP message parser: captures one byte word per cycle while it is empty or its word moves on.
// Depends on cmp_pkg and cmp_msg_if.
module cmp_byte_stage (
    input  logic              clk,
    input  logic              rst_n,
    cmp_msg_if.sink           msg,
    input  logic              advance,
    output logic              byte_valid,
    output cmp_pkg::cmp_byte_t byte_word
);

    logic               valid_reg;
    cmp_pkg::cmp_byte_t word_reg;
    logic               take;

    // The register refills whenever it is empty or its word moves on.
    assign msg.ready = !valid_reg || advance;
    assign take      = msg.valid && msg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (msg.ready)
        begin
            valid_reg <= msg.valid;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg.data <= msg.data_byte;
            word_reg.last <= msg.final_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_word  = word_reg;

endmodule

@@ sv/cmp_parse_core.sv @@
// Parse state of the CoAP message parser: header, token and option walk, one byte a cycle when stepped.
// Depends on cmp_pkg; produces the result word on the final byte.
module cmp_parse_core #(
    parameter int unsigned MAX_MESSAGE_LEN = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  cmp_pkg::cmp_byte_t   byte_word,
    output logic                 done,
    output cmp_pkg::cmp_result_t result_word
);

    // The byte counter saturates at MAX_MESSAGE_LEN + 1.
    localparam int unsigned IDX_W = $clog2(MAX_MESSAGE_LEN + 2);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_MESSAGE_LEN);

    logic [IDX_W-1:0]          byte_index_reg, byte_index_next;
    logic [3:0]                phase_reg, phase_next;
    logic [3:0]                token_left_reg, token_left_next;
    logic [7:0]                code_reg, code_next;
    logic [3:0]                tkl_reg, tkl_next;
    logic [3:0]                length_nibble_reg, length_nibble_next;
    logic [7:0]                ext_high_reg, ext_high_next;
    logic [cmp_pkg::SKIP_W-1:0] skip_left_reg, skip_left_next;
    logic [2:0]                error_code_reg, error_code_next;
    logic [IDX_W-1:0]          marker_offset_reg, marker_offset_next;

    logic [7:0]                 b;
    logic [IDX_W-1:0]           pos;
    logic [3:0]                 len_nib;
    logic [3:0]                 len_phase;
    logic [cmp_pkg::SKIP_W-1:0] len_skip;
    logic [cmp_pkg::SKIP_W-1:0] ext_value;
    logic [cmp_pkg::SKIP_W-1:0] skip_dec;
    logic [IDX_W-1:0]           msg_len;
    logic [IDX_W-1:0]           pay_count;

    assign b   = byte_word.data;
    assign pos = byte_index_reg;

    // Length nibble comes from this byte in the option phase, else from the saved one.
    assign len_nib = (phase_reg == cmp_pkg::PH_OPTION) ? b[3:0] : length_nibble_reg;
    assign len_skip = cmp_pkg::SKIP_W'(len_nib);

    // Phase that follows a completed delta part, driven by the length nibble.
    always_comb
    begin
        unique case (len_nib)
            cmp_pkg::NIB_RESERVED: len_phase = cmp_pkg::PH_ERROR;
            cmp_pkg::NIB_EXT1:     len_phase = cmp_pkg::PH_LEXT1;
            cmp_pkg::NIB_EXT2:     len_phase = cmp_pkg::PH_LEXT2A;
            default:               len_phase = (len_nib == 4'd0) ? cmp_pkg::PH_OPTION
                                                                 : cmp_pkg::PH_SKIP;
        endcase
    end

    // Extended option length, one-byte or two-byte form.
    assign ext_value = (phase_reg == cmp_pkg::PH_LEXT1)
                     ? cmp_pkg::SKIP_W'(b) + cmp_pkg::EXT1_BIAS
                     : cmp_pkg::SKIP_W'({ext_high_reg, b}) + cmp_pkg::EXT2_BIAS;
    assign skip_dec  = skip_left_reg - cmp_pkg::SKIP_W'(1);

    // Next parse state for the byte in the input register.
    always_comb
    begin
        phase_next         = phase_reg;
        token_left_next    = token_left_reg;
        code_next          = code_reg;
        tkl_next           = tkl_reg;
        length_nibble_next = length_nibble_reg;
        ext_high_next      = ext_high_reg;
        skip_left_next     = skip_left_reg;
        error_code_next    = error_code_reg;
        marker_offset_next = marker_offset_reg;

        unique case (phase_reg)
            cmp_pkg::PH_HEADER:
            begin
                if (pos == IDX_W'(0))
                begin
                    tkl_next = b[3:0];
                end
                else if (pos == IDX_W'(1))
                begin
                    code_next = b;
                end
                else if (pos >= IDX_W'(3))
                begin
                    token_left_next = tkl_reg;
                    phase_next = (tkl_reg == 4'd0) ? cmp_pkg::PH_OPTION : cmp_pkg::PH_TOKEN;
                end
            end
            cmp_pkg::PH_TOKEN:
            begin
                token_left_next = token_left_reg - 4'd1;
                if (token_left_reg == 4'd1)
                begin
                    phase_next = cmp_pkg::PH_OPTION;
                end
            end
            cmp_pkg::PH_OPTION:
            begin
                if (b == cmp_pkg::PAYLOAD_MARKER)
                begin
                    marker_offset_next = pos + IDX_W'(1);
                    phase_next = cmp_pkg::PH_PAYLOAD;
                end
                else
                begin
                    length_nibble_next = b[3:0];
                    if (b[7:4] == cmp_pkg::NIB_RESERVED)
                    begin
                        error_code_next = cmp_pkg::ST_NIBBLE15;
                        phase_next = cmp_pkg::PH_ERROR;
                    end
                    else if (b[7:4] == cmp_pkg::NIB_EXT1)
                    begin
                        phase_next = cmp_pkg::PH_DEXT1;
                    end
                    else if (b[7:4] == cmp_pkg::NIB_EXT2)
                    begin
                        phase_next = cmp_pkg::PH_DEXT2A;
                    end
                    else
                    begin
                        phase_next = len_phase;
                        skip_left_next = len_skip;
                        if (len_phase == cmp_pkg::PH_ERROR)
                        begin
                            error_code_next = cmp_pkg::ST_NIBBLE15;
                        end
                    end
                end
            end
            cmp_pkg::PH_DEXT1, cmp_pkg::PH_DEXT2B:
            begin
                phase_next = len_phase;
                skip_left_next = len_skip;
                if (len_phase == cmp_pkg::PH_ERROR)
                begin
                    error_code_next = cmp_pkg::ST_NIBBLE15;
                end
            end
            cmp_pkg::PH_DEXT2A:
            begin
                phase_next = cmp_pkg::PH_DEXT2B;
            end
            cmp_pkg::PH_LEXT1, cmp_pkg::PH_LEXT2B:
            begin
                skip_left_next = ext_value;
                phase_next = (ext_value == '0) ? cmp_pkg::PH_OPTION : cmp_pkg::PH_SKIP;
            end
            cmp_pkg::PH_LEXT2A:
            begin
                ext_high_next = b;
                phase_next = cmp_pkg::PH_LEXT2B;
            end
            cmp_pkg::PH_SKIP:
            begin
                skip_left_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = cmp_pkg::PH_OPTION;
                end
            end
            default:
            begin
                // Payload, error and unused codes absorb the byte.
            end
        endcase
    end

    // Saturating byte count; after this byte it is the message length so far.
    assign byte_index_next = (byte_index_reg <= IDX_MAX) ? byte_index_reg + IDX_W'(1)
                                                         : byte_index_reg;
    assign msg_len   = byte_index_next;
    assign pay_count = msg_len - marker_offset_next;

    // Result word, valid when the final byte is stepped.
    always_comb
    begin
        result_word.status        = cmp_pkg::ST_OK_NONE;
        result_word.payload_start = '0;
        result_word.payload_bytes = '0;
        if (msg_len > IDX_MAX)
        begin
            result_word.status = cmp_pkg::ST_TOO_LONG;
        end
        else if (error_code_next != 3'd0)
        begin
            result_word.status = error_code_next;
        end
        else if (msg_len < IDX_W'(4))
        begin
            result_word.status = cmp_pkg::ST_SHORT;
        end
        else if (phase_next == cmp_pkg::PH_TOKEN)
        begin
            result_word.status = cmp_pkg::ST_TOKEN;
        end
        else if (phase_next >= cmp_pkg::PH_DEXT1 && phase_next <= cmp_pkg::PH_LEXT2B)
        begin
            result_word.status = cmp_pkg::ST_EXT_CUT;
        end
        else if (phase_next == cmp_pkg::PH_SKIP)
        begin
            result_word.status = cmp_pkg::ST_OPT_OVER;
        end
        else if (phase_next == cmp_pkg::PH_PAYLOAD)
        begin
            result_word.status        = cmp_pkg::ST_OK_PAY;
            result_word.payload_start = cmp_pkg::PAY_W'(marker_offset_next);
            result_word.payload_bytes = cmp_pkg::PAY_W'(pay_count);
        end
        result_word.msg_code  = (msg_len >= IDX_W'(4)) ? code_next : 8'd0;
        result_word.token_len = tkl_next;
    end

    assign done = step && byte_word.last;

    // State registers; the final byte returns everything to the reset state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg    <= '0;
            phase_reg         <= cmp_pkg::PH_HEADER;
            token_left_reg    <= '0;
            code_reg          <= '0;
            tkl_reg           <= '0;
            length_nibble_reg <= '0;
            ext_high_reg      <= '0;
            skip_left_reg     <= '0;
            error_code_reg    <= '0;
            marker_offset_reg <= '0;
        end
        else if (done)
        begin
            byte_index_reg    <= '0;
            phase_reg         <= cmp_pkg::PH_HEADER;
            token_left_reg    <= '0;
            code_reg          <= '0;
            tkl_reg           <= '0;
            length_nibble_reg <= '0;
            ext_high_reg      <= '0;
            skip_left_reg     <= '0;
            error_code_reg    <= '0;
            marker_offset_reg <= '0;
        end
        else if (step)
        begin
            byte_index_reg    <= byte_index_next;
            phase_reg         <= phase_next;
            token_left_reg    <= token_left_next;
            code_reg          <= code_next;
            tkl_reg           <= tkl_next;
            length_nibble_reg <= length_nibble_next;
            ext_high_reg      <= ext_high_next;
            skip_left_reg     <= skip_left_next;
            error_code_reg    <= error_code_next;
            marker_offset_reg <= marker_offset_next;
        end
    end

endmodule

@@ sv/coap_message_parser.sv @@
// CoAP message parser: takes a message one byte word per cycle and, on the word
// flagged final, returns one result word with status, code, token length and the
// payload offset and count. Throughput is one byte per cycle, sustained across
// message boundaries; a result becomes valid once its final byte has passed through
// the input register and then been captured by the result register. The input side
// stalls only when a final byte reaches the parse stage while the previous result
// still waits in the result register. Messages longer than MAX_MESSAGE_LEN give
// the too-long status; the byte counter saturates so any length is safe.
// Depends on cmp_pkg, cmp_msg_if, cmp_result_if, cmp_byte_stage, cmp_parse_core.
`include "assert_macros.svh"

module coap_message_parser #(
    parameter int unsigned MAX_MESSAGE_LEN = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    cmp_msg_if.sink       msg,
    cmp_result_if.source  result
);

    logic                 byte_valid;
    cmp_pkg::cmp_byte_t   byte_word;
    logic                 advance;
    logic                 step;
    logic                 done;
    cmp_pkg::cmp_result_t core_result;
    logic                 out_valid_reg;
    cmp_pkg::cmp_result_t result_reg;

    // A byte moves on unless it is final and the result register is full and not being taken.
    assign advance = !byte_word.last || !out_valid_reg || result.ready;
    assign step    = byte_valid && advance;

    cmp_byte_stage u_byte_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg        (msg),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_word  (byte_word)
    );

    cmp_parse_core #(
        .MAX_MESSAGE_LEN (MAX_MESSAGE_LEN)
    ) u_parse_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .byte_word   (byte_word),
        .done        (done),
        .result_word (core_result)
    );

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            result_reg <= core_result;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = result_reg.status;
    assign result.msg_code      = result_reg.msg_code;
    assign result.token_len     = result_reg.token_len;
    assign result.payload_start = result_reg.payload_start;
    assign result.payload_bytes = result_reg.payload_bytes;

    // A new result never overwrites one that has not been taken.
    `CMP_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, done, !out_valid_reg || result.ready,
        "result register overwritten before it was taken")

    // A payload starts after the four header bytes and the marker.
    `CMP_ASSERT_IMPLY(a_payload_offset, clk, rst_n,
        out_valid_reg && result_reg.status == cmp_pkg::ST_OK_PAY,
        result_reg.payload_start >= cmp_pkg::PAY_W'(5),
        "payload offset inside the header")

    // Payload fields are zero for every status other than ok with payload.
    `CMP_ASSERT_IMPLY(a_payload_zero, clk, rst_n,
        out_valid_reg && result_reg.status != cmp_pkg::ST_OK_PAY,
        result_reg.payload_start == '0 && result_reg.payload_bytes == '0,
        "payload fields set without a payload")

    // A final byte that steps the parser always shows up as a result next cycle.
    `CMP_ASSERT_NEXT(a_done_visible, clk, rst_n, done, out_valid_reg,
        "final byte did not produce a result")

endmodule
